@@ hdl/htw_pkg.sv @@
// Package for the hashed timer wheel block.
// Holds the transfer payload types, command and status codes, and reciprocal divide constants.
// No dependencies.
package htw_pkg;

    // Input transfer: one command
    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  timer_id;
        logic [23:0] delay_ms;
    } t_in;

    // Output transfer: one result
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic       last;
    } t_out;

    // Command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_EXPIRED = 2'd2;
    localparam logic [1:0] ST_NO_EXP  = 2'd3;

    // Tick rate register
    localparam int          RATE_W     = 14;
    localparam logic [13:0] RATE_RESET = 14'd1000;

    // Millisecond conversion: (delay_ms * tick_rate) / 1000
    // split as delay_ms = a*1000 + b, giving a*rate + (b*rate)/1000.
    // Both divides use x*RECIP_M >> RECIP_SHIFT, exact for any 24-bit x.
    localparam int          MS_DIV      = 1000;
    localparam int          MS_W        = 24;
    localparam int          RECIP_W     = 25;
    localparam int          RECIP_SHIFT = 34;
    localparam logic [24:0] RECIP_M     = 25'd17179870;
    localparam int          A_W         = 15;
    localparam int          B_W         = 10;
    localparam int          QUO_W       = 29;

    // Most expiries reported for one tick
    localparam int MAX_RESULTS = 16;
    localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

endpackage

@@ hdl/hashed_timer_wheel.sv @@
// Hashed timer wheel: a pool of one-shot timers with an ordered arm list.
// An add is accepted, converted in four steps (divide by 1000, remainder, scale, divide by 1000),
// armed, and its result emitted; an ignored command or a tick with nothing running goes straight
// to the result. Delete and tick scan the whole arm list. Output stalls hold the sequencer.
// Synchronous active-low reset clears the tick count, running flags, arm list count and
// output valid, and loads a tick rate of 1000; deadline and arm list entries are written first.
module hashed_timer_wheel
    import htw_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out,
    input  logic              i_cfg_we,
    input  logic [RATE_W-1:0] i_cfg_data
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_Q1     = 4'd1;
    localparam logic [3:0] S_REM    = 4'd2;
    localparam logic [3:0] S_SCALE  = 4'd3;
    localparam logic [3:0] S_Q2     = 4'd4;
    localparam logic [3:0] S_ARM    = 4'd5;
    localparam logic [3:0] S_RD_ORD = 4'd6;
    localparam logic [3:0] S_RD_DL  = 4'd7;
    localparam logic [3:0] S_CMP    = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]            r_state;
    logic [1:0]            r_cmd;
    logic [IW-1:0]         r_slot;
    logic [3:0]            r_id;
    logic [RATE_W-1:0]     r_rate;
    logic [TICK_BITS-1:0]  r_now;
    logic [NUM_TIMERS-1:0] r_run;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_rd;
    logic [CW-1:0]         r_wr;
    logic [HIT_W-1:0]      r_hits;
    logic                  r_pend_v;
    logic [IW-1:0]         r_pend_slot;
    t_out                  r_res;
    t_out                  r_out;
    logic                  r_out_valid;
    logic [MS_W-1:0]       r_x;
    logic [A_W-1:0]        r_a;
    logic [QUO_W-1:0]      r_acc;

    // Arm list (slot ids, oldest first) and deadlines
    logic [IW-1:0]         r_ord [NUM_TIMERS];
    logic [TICK_BITS-1:0]  r_dl  [NUM_TIMERS];
    logic [IW-1:0]         r_ord_q;
    logic [TICK_BITS-1:0]  r_dl_q;

    logic                      in_acc;
    logic                      out_free;
    logic                      out_load;
    logic                      id_ok;
    logic [IW-1:0]             id_idx;
    logic [MS_W+RECIP_W-1:0]   recip_prod;
    logic [A_W-1:0]            recip_q;
    logic                      n_hit;
    logic                      scan_wait;
    logic                      scan_end;
    logic                      ord_we;
    logic [IW-1:0]             ord_wa;
    logic [IW-1:0]             ord_wd;
    logic                      fin_pend_v;
    logic [IW-1:0]             fin_pend_slot;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign id_ok    = (32'(i_in.timer_id) < 32'(NUM_TIMERS));
    assign id_idx   = IW'(i_in.timer_id);

    // Shared divide by 1000: reciprocal multiply and shift
    assign recip_prod = (MS_W + RECIP_W)'(r_x) * (MS_W + RECIP_W)'(RECIP_M);
    assign recip_q    = recip_prod[RECIP_SHIFT +: A_W];

    // Scan compare: expiry for tick, match of the deleted slot for delete
    always_comb begin
        if (r_cmd == CMD_TICK) begin
            n_hit = (r_dl_q == r_now) && (r_hits != HIT_W'(MAX_RESULTS));
        end else begin
            n_hit = (r_ord_q == r_slot);
        end
    end

    assign scan_wait     = (r_cmd == CMD_TICK) && n_hit && r_pend_v && !out_free;
    assign scan_end      = ((r_rd + 1'b1) == r_cnt);
    assign fin_pend_v    = n_hit || r_pend_v;
    assign fin_pend_slot = n_hit ? r_ord_q : r_pend_slot;

    // Output register loads on a final result or on an earlier expiry
    assign out_load = out_free &&
                      ((r_state == S_EMIT) ||
                       (r_state == S_CMP && r_cmd == CMD_TICK && n_hit && r_pend_v));

    // Arm list write port: append on arm, compact during scan
    always_comb begin
        ord_we = 1'b0;
        ord_wa = r_wr[IW-1:0];
        ord_wd = r_ord_q;
        if (r_state == S_ARM) begin
            ord_we = 1'b1;
            ord_wa = r_cnt[IW-1:0];
            ord_wd = r_slot;
        end else if (r_state == S_CMP && !scan_wait && !n_hit) begin
            ord_we = 1'b1;
        end
    end

    // Arm list and deadline storage
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_ord[ord_wa] <= ord_wd;
        end
        if (r_state == S_ARM) begin
            r_dl[r_slot] <= r_now + TICK_BITS'(r_acc);
        end
        if (r_state == S_RD_ORD) begin
            r_ord_q <= r_ord[r_rd[IW-1:0]];
        end
        if (r_state == S_RD_DL) begin
            r_dl_q <= r_dl[r_ord_q];
        end
    end

    // Tick rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_data;
        end
    end

    // Sequencer, divider and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_run       <= '0;
            r_cnt       <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_hits      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // raise valid on a load, drop the result once taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= i_in.command;
                        r_slot <= id_idx;
                        r_id   <= i_in.timer_id;
                        r_rd   <= '0;
                        r_wr   <= '0;
                        case (i_in.command)
                            CMD_ADD: begin
                                if (!id_ok || r_run[id_idx]) begin
                                    r_res   <= '{status: ST_IGNORED, slot: i_in.timer_id,
                                                 last: 1'b1};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_x     <= i_in.delay_ms;
                                    r_state <= S_Q1;
                                end
                            end
                            CMD_DEL: begin
                                if (!id_ok || !r_run[id_idx]) begin
                                    r_res   <= '{status: ST_IGNORED, slot: i_in.timer_id,
                                                 last: 1'b1};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_run[id_idx] <= 1'b0;
                                    r_res   <= '{status: ST_DONE, slot: i_in.timer_id,
                                                 last: 1'b1};
                                    r_state <= S_RD_ORD;
                                end
                            end
                            CMD_TICK: begin
                                r_now    <= r_now + 1'b1;
                                r_hits   <= '0;
                                r_pend_v <= 1'b0;
                                if (r_cnt == '0) begin
                                    r_res   <= '{status: ST_NO_EXP, slot: 4'd0, last: 1'b1};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_RD_ORD;
                                end
                            end
                            default: begin
                                r_res   <= '{status: ST_IGNORED, slot: i_in.timer_id,
                                             last: 1'b1};
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end

                // whole seconds: a = delay_ms / 1000
                S_Q1: begin
                    r_a     <= recip_q;
                    r_state <= S_REM;
                end

                // b = delay_ms - a*1000, start the sum with a*rate
                S_REM: begin
                    r_x     <= r_x - (MS_W'(r_a) * MS_W'(MS_DIV));
                    r_acc   <= QUO_W'(r_a) * QUO_W'(r_rate);
                    r_state <= S_SCALE;
                end

                S_SCALE: begin
                    r_x     <= MS_W'(r_x[B_W-1:0]) * MS_W'(r_rate);
                    r_state <= S_Q2;
                end

                // add (b*rate) / 1000
                S_Q2: begin
                    r_acc   <= r_acc + QUO_W'(recip_q);
                    r_state <= S_ARM;
                end

                S_ARM: begin
                    r_run[r_slot] <= 1'b1;
                    r_cnt   <= r_cnt + 1'b1;
                    r_res   <= '{status: ST_DONE, slot: r_id, last: 1'b1};
                    r_state <= S_EMIT;
                end

                S_RD_ORD: begin
                    r_state <= (r_cmd == CMD_TICK) ? S_RD_DL : S_CMP;
                end

                S_RD_DL: begin
                    r_state <= S_CMP;
                end

                S_CMP: begin
                    if (!scan_wait) begin
                        if (n_hit) begin
                            if (r_cmd == CMD_TICK) begin
                                // hold the newest expiry; send the previous one
                                r_run[r_ord_q] <= 1'b0;
                                r_hits         <= r_hits + 1'b1;
                                r_pend_v       <= 1'b1;
                                r_pend_slot    <= r_ord_q;
                                if (r_pend_v) begin
                                    r_out <= '{status: ST_EXPIRED,
                                               slot: 4'(r_pend_slot), last: 1'b0};
                                end
                            end
                        end else begin
                            r_wr <= r_wr + 1'b1;
                        end
                        r_rd <= r_rd + 1'b1;
                        if (scan_end) begin
                            r_cnt <= n_hit ? r_wr : (r_wr + 1'b1);
                            if (r_cmd == CMD_TICK) begin
                                if (fin_pend_v) begin
                                    r_res <= '{status: ST_EXPIRED,
                                               slot: 4'(fin_pend_slot), last: 1'b1};
                                end else begin
                                    r_res <= '{status: ST_NO_EXP, slot: 4'd0, last: 1'b1};
                                end
                            end
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_RD_ORD;
                        end
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
